// ----- hdl/ncps_pkg.sv -----
// shared types, constants and trigger template table of the navigation cycle sequencer
`default_nettype none

package ncps_pkg;

    // fixed field widths
    localparam int PHASE_W     = 10;
    localparam int POWER_W     = 8;
    localparam int POS_W       = 11;
    localparam int GOLD_W      = 6;
    localparam int CLKCNT_W    = 16;
    localparam int SLOT_T_W    = 7;
    localparam int SLOT_K_W    = 3;
    localparam int SLOT_NUM_W  = 5;
    localparam int ROM_ADDR_W  = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // template length and derived rom layout
    localparam int TEMPLATE_LEN = 40;
    localparam int ROM_DEPTH    = 4 * TEMPLATE_LEN;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_ZERO = 10'd499;
    localparam logic [PHASE_W-1:0] PH_GAP  = 10'd238;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_COMP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_FLOOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_CEIL   = 2'd3;

    // 64-bit gold code, bit g selects the trigger template of cycle g
    localparam logic [63:0] GOLD_CODE = {32'hAE32BD97, 32'hFA9B8700};

    // input beat
    typedef struct packed {
        logic                  cmd;
        logic [4:0]            slot_index;
        logic [PHASE_W-1:0]    slot_offset;
        logic [POWER_W-1:0]    slot_power;
    } ncps_in_t;

    // result beat
    typedef struct packed {
        logic [PHASE_W-1:0]    ch1_phase;
        logic [PHASE_W-1:0]    ch2_phase;
        logic [POWER_W-1:0]    f1_power;
        logic [POWER_W-1:0]    f2_power;
        logic                  cycle_end;
    } ncps_out_t;

    // configuration registers
    typedef struct packed {
        logic                  interlaced_mode;
        logic                  receiver_compensation;
        logic [POWER_W-1:0]    power_floor;
        logic [POWER_W-1:0]    power_ceiling;
    } ncps_cfg_t;

    // slot table entry
    typedef struct packed {
        logic [PHASE_W-1:0]    offset;
        logic [POWER_W-1:0]    power;
    } ncps_slot_t;

    localparam int SLOT_W = $bits(ncps_slot_t);

    // one channel's phase and amplitude
    typedef struct packed {
        logic [PHASE_W-1:0]    phase;
        logic [POWER_W-1:0]    power;
    } ncps_chan_t;

    // what drives a channel in a given millisecond
    typedef enum logic [2:0] {
        CH_IDLE,
        CH_CEIL,
        CH_ROM,
        CH_SLOT,
        CH_GAP
    } ncps_chan_mode_t;

    // decoded tick handed from the sequencer to the evaluation stage
    typedef struct packed {
        ncps_chan_mode_t         f1_mode;
        ncps_chan_mode_t         f2_mode;
        logic [ROM_ADDR_W-1:0]   rom_addr;
        logic [PHASE_W-1:0]      ramp;
        logic                    a_in_table;
        logic                    a_written;
        logic                    b_in_table;
        logic                    b_written;
        logic                    cycle_end;
    } ncps_ctx_t;

    // sine templates: [compensation][50 Hz, 37.5 Hz][n]
    localparam logic [PHASE_W-1:0] TRIGGER_ROM [ROM_DEPTH] = '{
        // ideal, 50 Hz
        10'd499, 10'd638, 10'd764, 10'd863, 10'd927, 10'd949, 10'd927, 10'd863, 10'd764, 10'd638,
        10'd499, 10'd360, 10'd234, 10'd135, 10'd71,  10'd49,  10'd71,  10'd135, 10'd234, 10'd360,
        10'd499, 10'd638, 10'd764, 10'd863, 10'd927, 10'd949, 10'd927, 10'd863, 10'd764, 10'd638,
        10'd499, 10'd360, 10'd234, 10'd135, 10'd71,  10'd49,  10'd71,  10'd135, 10'd234, 10'd360,
        // ideal, 37.5 Hz
        10'd499, 10'd394, 10'd295, 10'd207, 10'd135, 10'd83,  10'd55,  10'd50,  10'd71,  10'd115,
        10'd181, 10'd264, 10'd360, 10'd464, 10'd569, 10'd671, 10'd764, 10'd841, 10'd900, 10'd937,
        10'd949, 10'd937, 10'd900, 10'd841, 10'd764, 10'd671, 10'd569, 10'd464, 10'd360, 10'd264,
        10'd181, 10'd115, 10'd71,  10'd50,  10'd55,  10'd83,  10'd135, 10'd207, 10'd295, 10'd394,
        // compensated, 50 Hz
        10'd640, 10'd765, 10'd864, 10'd927, 10'd949, 10'd926, 10'd862, 10'd762, 10'd637, 10'd497,
        10'd358, 10'd233, 10'd134, 10'd71,  10'd50,  10'd72,  10'd136, 10'd236, 10'd361, 10'd501,
        10'd640, 10'd765, 10'd864, 10'd927, 10'd949, 10'd926, 10'd862, 10'd762, 10'd637, 10'd497,
        10'd358, 10'd233, 10'd134, 10'd71,  10'd50,  10'd72,  10'd136, 10'd236, 10'd361, 10'd501,
        // compensated, 37.5 Hz
        10'd392, 10'd293, 10'd205, 10'd134, 10'd82,  10'd54,  10'd51,  10'd72,  10'd117, 10'd182,
        10'd266, 10'd362, 10'd466, 10'd572, 10'd673, 10'd765, 10'd843, 10'd901, 10'd937, 10'd949,
        10'd936, 10'd899, 10'd840, 10'd762, 10'd669, 10'd567, 10'd461, 10'd358, 10'd262, 10'd179,
        10'd114, 10'd70,  10'd50,  10'd55,  10'd84,  10'd136, 10'd209, 10'd297, 10'd396, 10'd501
    };

endpackage

`default_nettype wire

// ----- hdl/ncps_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module ncps_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ncps_seq.sv -----
// cycle position counters, period decode, slot table addressing and write control
`default_nettype none

module ncps_seq #(
    parameter int SLOTS_PER_CYCLE = 8,
    parameter int SLOTS_TOTAL     = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ncps_pkg::ncps_cfg_t           cfg,
    input  wire logic                          tick_fire,
    input  wire logic                          wr_fire,
    input  wire ncps_pkg::ncps_in_t            in_beat,
    output ncps_pkg::ncps_ctx_t                ctx,
    output logic [$clog2(SLOTS_TOTAL)-1:0]     rd_addr_a,
    output logic [$clog2(SLOTS_TOTAL)-1:0]     rd_addr_b,
    output logic                               wr_en,
    output logic [$clog2(SLOTS_TOTAL)-1:0]     wr_addr,
    output ncps_pkg::ncps_slot_t               wr_data
);

    localparam int ADDR_W   = $clog2(SLOTS_TOTAL);
    localparam int NAV_LEN  = SLOTS_PER_CYCLE * 80;
    localparam int F1_START = 340;
    localparam int F2_START = F1_START + NAV_LEN + 40;
    localparam int CYCLE_MS = F2_START + NAV_LEN + 20;

    localparam logic [ncps_pkg::POS_W-1:0] TRIG_BEGIN = 11'd45;
    localparam logic [ncps_pkg::POS_W-1:0] TRIG_END   = 11'd85;
    localparam logic [ncps_pkg::POS_W-1:0] CLK_BEGIN  = 11'd95;
    localparam logic [ncps_pkg::POS_W-1:0] CLK_END    = 11'd115;
    localparam logic [ncps_pkg::POS_W-1:0] SET2_END   = 11'd120;
    localparam logic [ncps_pkg::POS_W-1:0] SET3_BEGIN = 11'd300;
    localparam logic [ncps_pkg::POS_W-1:0] F1_BEGIN   = ncps_pkg::POS_W'(F1_START);
    localparam logic [ncps_pkg::POS_W-1:0] F1_END     = ncps_pkg::POS_W'(F1_START + NAV_LEN);
    localparam logic [ncps_pkg::POS_W-1:0] F2_BEGIN   = ncps_pkg::POS_W'(F2_START);
    localparam logic [ncps_pkg::POS_W-1:0] F2_END     = ncps_pkg::POS_W'(F2_START + NAV_LEN);
    localparam logic [ncps_pkg::POS_W-1:0] LAST_MS    = ncps_pkg::POS_W'(CYCLE_MS - 1);
    localparam logic [5:0] CLK_LEN = 6'(ncps_pkg::TEMPLATE_LEN / 2);
    localparam logic [ncps_pkg::SLOT_K_W-1:0] LAST_K = ncps_pkg::SLOT_K_W'(SLOTS_PER_CYCLE - 1);
    localparam logic [ncps_pkg::SLOT_NUM_W-1:0] TOTAL_NUM =
        ncps_pkg::SLOT_NUM_W'(SLOTS_TOTAL);

    logic [ncps_pkg::POS_W-1:0]    ms_pos_reg,    ms_pos_next;
    logic [ncps_pkg::GOLD_W-1:0]   gold_reg,      gold_next;
    logic [ncps_pkg::CLKCNT_W-1:0] clk_count_reg, clk_count_next;
    logic [ncps_pkg::SLOT_T_W-1:0] slot_t_reg,    slot_t_next;
    logic [ncps_pkg::SLOT_K_W-1:0] slot_k_reg,    slot_k_next;
    logic [SLOTS_TOTAL-1:0]        written_reg;

    logic [ncps_pkg::POS_W-1:0]    p;
    logic [5:0]                    trig_off;
    logic [4:0]                    clk_off;
    logic [1:0]                    dibit;
    logic [5:0]                    clk_idx;
    logic [5:0]                    clk_idx_wrap;
    logic [ncps_pkg::ROM_ADDR_W-1:0] rom_base;
    logic [11:0]                   ramp_prod;
    logic [11:0]                   ramp_raw;
    logic [11:0]                   ramp_half;
    logic [ncps_pkg::SLOT_NUM_W-1:0] k_num;
    logic [ncps_pkg::SLOT_NUM_W-1:0] a_num;
    logic [ncps_pkg::SLOT_NUM_W-1:0] b_num;
    logic                          in_nav;
    logic                          last_ms;

    // rotation of the clock template for each dibit value
    function automatic logic [3:0] clock_shift(input logic [1:0] bits);
        logic [3:0] sh;
        unique case (bits)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd5;
            2'd2:    sh = 4'd15;
            2'd3:    sh = 4'd10;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    // template addressing for trigger and clock periods
    always_comb begin
        p            = ms_pos_reg;
        trig_off     = 6'(p - TRIG_BEGIN);
        clk_off      = 5'(p - CLK_BEGIN);
        dibit        = clk_count_reg[{gold_reg[2:0], 1'b0} +: 2] ^ {2{gold_reg[5]}};
        clk_idx      = 6'(clk_off) + 6'(clock_shift(dibit));
        clk_idx_wrap = (clk_idx >= CLK_LEN) ? clk_idx - CLK_LEN : clk_idx;
        rom_base     = cfg.receiver_compensation ?
                       ncps_pkg::ROM_ADDR_W'(2 * ncps_pkg::TEMPLATE_LEN) : '0;
    end

    // ramp of the nav slot, reduced mod 1000
    always_comb begin
        ramp_prod = 12'(slot_t_reg) * 12'd40;
        ramp_raw  = (slot_t_reg < 7'd40) ? ramp_prod : 12'd3600 - ramp_prod;
        ramp_half = (ramp_raw >= 12'd2000) ? ramp_raw - 12'd2000 : ramp_raw;
    end

    // period decode and slot selection
    always_comb begin
        k_num   = ncps_pkg::SLOT_NUM_W'(slot_k_reg);
        a_num   = k_num;
        b_num   = k_num;
        in_nav  = 1'b0;
        last_ms = (p == LAST_MS);

        ctx            = '0;
        ctx.f1_mode    = ncps_pkg::CH_IDLE;
        ctx.f2_mode    = ncps_pkg::CH_IDLE;
        ctx.ramp       = ncps_pkg::PHASE_W'((ramp_half >= 12'd1000) ?
                                            ramp_half - 12'd1000 : ramp_half);
        ctx.cycle_end  = last_ms;

        priority if (p < TRIG_BEGIN || (p >= TRIG_END && p < CLK_BEGIN) ||
                     (p >= CLK_END && p < SET2_END) || (p >= SET3_BEGIN && p < F1_BEGIN)) begin
            ctx.f1_mode = ncps_pkg::CH_CEIL;
        end else if (p < TRIG_END) begin
            ctx.f1_mode  = ncps_pkg::CH_ROM;
            ctx.rom_addr = rom_base + (ncps_pkg::GOLD_CODE[gold_reg] ?
                           ncps_pkg::ROM_ADDR_W'(ncps_pkg::TEMPLATE_LEN) : '0) +
                           ncps_pkg::ROM_ADDR_W'(trig_off);
        end else if (p >= CLK_BEGIN && p < CLK_END) begin
            ctx.f1_mode  = ncps_pkg::CH_ROM;
            ctx.rom_addr = rom_base + ncps_pkg::ROM_ADDR_W'(clk_idx_wrap);
        end else if (p >= F1_BEGIN && p < F1_END) begin
            in_nav      = 1'b1;
            ctx.f1_mode = ncps_pkg::CH_SLOT;
            b_num       = k_num + (gold_reg[0] ? 5'd16 : 5'd8);
            if (cfg.interlaced_mode) begin
                ctx.f2_mode = ncps_pkg::CH_SLOT;
            end
        end else if (p >= F2_BEGIN && p < F2_END) begin
            in_nav      = 1'b1;
            ctx.f2_mode = ncps_pkg::CH_SLOT;
            a_num       = k_num + (gold_reg[0] ? 5'd8 : 5'd16);
            if (cfg.interlaced_mode) begin
                ctx.f1_mode = ncps_pkg::CH_SLOT;
            end
        end else begin
            ctx.f1_mode = ncps_pkg::CH_GAP;
            ctx.f2_mode = ncps_pkg::CH_GAP;
        end

        rd_addr_a      = a_num[ADDR_W-1:0];
        rd_addr_b      = b_num[ADDR_W-1:0];
        ctx.a_in_table = (a_num < TOTAL_NUM);
        ctx.b_in_table = (b_num < TOTAL_NUM);
        ctx.a_written  = ctx.a_in_table && written_reg[rd_addr_a];
        ctx.b_written  = ctx.b_in_table && written_reg[rd_addr_b];
    end

    // next cycle position
    always_comb begin
        ms_pos_next    = last_ms ? '0 : p + 1'b1;
        gold_next      = last_ms ? gold_reg + 1'b1 : gold_reg;
        clk_count_next = (last_ms && gold_reg == '1) ? clk_count_reg + 1'b1 : clk_count_reg;
        slot_t_next    = slot_t_reg;
        slot_k_next    = slot_k_reg;
        if (in_nav) begin
            if (slot_t_reg == 7'd79) begin
                slot_t_next = '0;
                slot_k_next = (slot_k_reg == LAST_K) ? '0 : slot_k_reg + 1'b1;
            end else begin
                slot_t_next = slot_t_reg + 1'b1;
            end
        end
    end

    // slot table write beat
    always_comb begin
        wr_en          = wr_fire && (in_beat.slot_index < TOTAL_NUM);
        wr_addr        = in_beat.slot_index[ADDR_W-1:0];
        wr_data.offset = in_beat.slot_offset;
        wr_data.power  = in_beat.slot_power;
    end

    // position state, advanced once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_pos_reg    <= '0;
            gold_reg      <= '0;
            clk_count_reg <= '0;
            slot_t_reg    <= '0;
            slot_k_reg    <= '0;
        end else if (tick_fire) begin
            ms_pos_reg    <= ms_pos_next;
            gold_reg      <= gold_next;
            clk_count_reg <= clk_count_next;
            slot_t_reg    <= slot_t_next;
            slot_k_reg    <= slot_k_next;
        end
    end

    // entry written flags, unwritten entries read as offset 0 at amplitude 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ncps_eval.sv -----
// slot evaluation, channel selection and output register of the sequencer
`default_nettype none

module ncps_eval (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ncps_pkg::ncps_cfg_t     cfg,
    input  wire logic                    load,
    input  wire ncps_pkg::ncps_ctx_t     ctx,
    input  wire ncps_pkg::ncps_slot_t    slot_a,
    input  wire ncps_pkg::ncps_slot_t    slot_b,
    output logic                         take_ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output ncps_pkg::ncps_out_t          m_data
);

    logic                  s1_valid_reg, s1_valid_next;
    ncps_pkg::ncps_ctx_t   ctx_reg;
    logic                  out_valid_reg, out_valid_next;
    ncps_pkg::ncps_out_t   out_data_reg;

    logic                  out_free;
    logic                  s1_adv;
    ncps_pkg::ncps_chan_t  slot_res_a;
    ncps_pkg::ncps_chan_t  slot_res_b;
    ncps_pkg::ncps_chan_t  ch1;
    ncps_pkg::ncps_chan_t  ch2;
    ncps_pkg::ncps_out_t   result;

    // phase and amplitude of one nav slot
    function automatic ncps_pkg::ncps_chan_t slot_eval(
        input logic                          in_table,
        input logic                          written,
        input ncps_pkg::ncps_slot_t          entry,
        input logic [ncps_pkg::PHASE_W-1:0]  ramp,
        input logic [ncps_pkg::POWER_W-1:0]  floor_pw
    );
        ncps_pkg::ncps_chan_t          res;
        logic [ncps_pkg::PHASE_W-1:0]  off;
        logic [11:0]                   sum;
        logic [11:0]                   sum_half;
        off = (in_table && written) ? entry.offset : '0;
        if (!in_table) begin
            res.power = floor_pw;
        end else if (written) begin
            res.power = entry.power;
        end else begin
            res.power = '0;
        end
        sum      = 12'(ncps_pkg::PH_ZERO) + 12'(off) + 12'(ramp);
        sum_half = (sum >= 12'd2000) ? sum - 12'd2000 : sum;
        if (res.power > floor_pw) begin
            res.phase = ncps_pkg::PHASE_W'((sum_half >= 12'd1000) ?
                                           sum_half - 12'd1000 : sum_half);
        end else begin
            res.phase = ncps_pkg::PH_ZERO;
        end
        return res;
    endfunction

    // one channel from its mode
    function automatic ncps_pkg::ncps_chan_t chan_pick(
        input ncps_pkg::ncps_chan_mode_t        mode,
        input ncps_pkg::ncps_chan_t             slot_res,
        input logic [ncps_pkg::ROM_ADDR_W-1:0]  rom_addr,
        input ncps_pkg::ncps_cfg_t              c
    );
        ncps_pkg::ncps_chan_t res;
        unique case (mode)
            ncps_pkg::CH_IDLE: begin
                res.phase = ncps_pkg::PH_ZERO;
                res.power = c.power_floor;
            end
            ncps_pkg::CH_CEIL: begin
                res.phase = ncps_pkg::PH_ZERO;
                res.power = c.power_ceiling;
            end
            ncps_pkg::CH_ROM: begin
                res.phase = ncps_pkg::TRIGGER_ROM[rom_addr];
                res.power = c.power_ceiling;
            end
            ncps_pkg::CH_SLOT: begin
                res = slot_res;
            end
            ncps_pkg::CH_GAP: begin
                res.phase = ncps_pkg::PH_GAP;
                res.power = c.power_floor;
            end
            default: begin
                res.phase = ncps_pkg::PH_ZERO;
                res.power = c.power_floor;
            end
        endcase
        return res;
    endfunction

    // handshake between the decode stage and the output register
    always_comb begin
        out_free       = !out_valid_reg || m_ready;
        s1_adv         = s1_valid_reg && out_free;
        take_ready     = !s1_valid_reg || out_free;
        s1_valid_next  = load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // result assembly from the slot table read data
    always_comb begin
        slot_res_a = slot_eval(ctx_reg.a_in_table, ctx_reg.a_written, slot_a,
                               ctx_reg.ramp, cfg.power_floor);
        slot_res_b = slot_eval(ctx_reg.b_in_table, ctx_reg.b_written, slot_b,
                               ctx_reg.ramp, cfg.power_floor);
        ch1 = chan_pick(ctx_reg.f1_mode, slot_res_a, ctx_reg.rom_addr, cfg);
        ch2 = chan_pick(ctx_reg.f2_mode, slot_res_b, ctx_reg.rom_addr, cfg);
        result.ch1_phase = ch1.phase;
        result.f1_power  = ch1.power;
        result.ch2_phase = ch2.phase;
        result.f2_power  = ch2.power;
        result.cycle_end = ctx_reg.cycle_end;
    end

    // stage and output valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage and output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            ctx_reg <= ctx;
        end
        if (s1_adv) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hdl/nav_cycle_phase_sequencer_core.sv -----
// top level of the navigation cycle phase sequencer
// Each tick beat (cmd 0) yields one result beat giving both channels' phase and
// amplitude for one millisecond of the navigation cycle; a write beat (cmd 1) loads
// one slot table entry and yields no result. The block takes one beat per clock
// cycle unless a held result stalls a full pipeline. The edge that accepts a tick
// captures the decoded cycle position and the slot table read, whose two copies
// (one per channel) have a registered read port; the output register takes the result
// once it is empty or being read out, and m_valid rises when it is loaded.
// A write is visible to a tick accepted in the following cycle. Slot entries never
// written read as offset 0 at amplitude 0; no clearing pass is needed after reset.
// Configuration writes are taken in any cycle but belong to idle periods.
`default_nettype none

module nav_cycle_phase_sequencer_core #(
    parameter int SLOTS_PER_CYCLE = 8,
    parameter int SLOTS_TOTAL     = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire ncps_pkg::ncps_in_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output ncps_pkg::ncps_out_t                     m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ncps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ncps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(SLOTS_TOTAL);

    ncps_pkg::ncps_cfg_t   cfg_reg, cfg_next;
    logic                  take_ready;
    logic                  tick_fire;
    logic                  wr_fire;
    ncps_pkg::ncps_ctx_t   ctx;
    logic [ADDR_W-1:0]     rd_addr_a;
    logic [ADDR_W-1:0]     rd_addr_b;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    ncps_pkg::ncps_slot_t  wr_data;
    ncps_pkg::ncps_slot_t  slot_a;
    ncps_pkg::ncps_slot_t  slot_b;

    // input beat decode
    assign s_ready   = take_ready;
    assign tick_fire = s_valid && take_ready && (s_data.cmd == ncps_pkg::CMD_TICK);
    assign wr_fire   = s_valid && take_ready && (s_data.cmd == ncps_pkg::CMD_WRITE);
    assign cfg_ready = 1'b1;

    // configuration register write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ncps_pkg::CFG_INTERLACED: cfg_next.interlaced_mode       = cfg_data[0];
                ncps_pkg::CFG_RX_COMP:    cfg_next.receiver_compensation = cfg_data[0];
                ncps_pkg::CFG_PWR_FLOOR:  cfg_next.power_floor           = cfg_data;
                ncps_pkg::CFG_PWR_CEIL:   cfg_next.power_ceiling         = cfg_data;
                default:                  cfg_next                       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interlaced_mode       <= 1'b0;
            cfg_reg.receiver_compensation <= 1'b0;
            cfg_reg.power_floor           <= '0;
            cfg_reg.power_ceiling         <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // cycle position and slot addressing
    ncps_seq #(
        .SLOTS_PER_CYCLE (SLOTS_PER_CYCLE),
        .SLOTS_TOTAL     (SLOTS_TOTAL)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .tick_fire (tick_fire),
        .wr_fire   (wr_fire),
        .in_beat   (s_data),
        .ctx       (ctx),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // slot table copy read for channel one
    ncps_ram #(
        .WIDTH (ncps_pkg::SLOT_W),
        .DEPTH (SLOTS_TOTAL)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (tick_fire),
        .raddr (rd_addr_a),
        .rdata (slot_a)
    );

    // slot table copy read for channel two
    ncps_ram #(
        .WIDTH (ncps_pkg::SLOT_W),
        .DEPTH (SLOTS_TOTAL)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (tick_fire),
        .raddr (rd_addr_b),
        .rdata (slot_b)
    );

    // slot evaluation and result register
    ncps_eval u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .load       (tick_fire),
        .ctx        (ctx),
        .slot_a     (slot_a),
        .slot_b     (slot_b),
        .take_ready (take_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/ncps_checker.sv -----
`timescale 1ns / 100ps
// result checker for the navigation cycle sequencer: predicts every millisecond beat and compares
module ncps_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire ncps_pkg::ncps_in_t              s_data,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire ncps_pkg::ncps_out_t             m_data,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [ncps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ncps_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   mismatches,
    output int                                   outstanding
);

    // cycle layout in milliseconds
    localparam int NAV_SLOTS   = 8;
    localparam int TABLE_SLOTS = 24;
    localparam int F1_FIRST    = 340;
    localparam int F2_FIRST    = F1_FIRST + NAV_SLOTS * 80 + 40;
    localparam int CYCLE_LEN   = F2_FIRST + NAV_SLOTS * 80 + 20;
    localparam int ZERO_PHASE  = 499;
    localparam int GAP_PHASE   = 238;

    // bit g picks the 37.5 Hz trigger in cycle g
    localparam logic [63:0] GOLD_SEQ = 64'hAE32BD97_FA9B8700;

    // sine templates: [compensated][50 Hz, 37.5 Hz][n]
    localparam int TONE_ROM [160] = '{
        499, 638, 764, 863, 927, 949, 927, 863, 764, 638,
        499, 360, 234, 135, 71,  49,  71,  135, 234, 360,
        499, 638, 764, 863, 927, 949, 927, 863, 764, 638,
        499, 360, 234, 135, 71,  49,  71,  135, 234, 360,
        499, 394, 295, 207, 135, 83,  55,  50,  71,  115,
        181, 264, 360, 464, 569, 671, 764, 841, 900, 937,
        949, 937, 900, 841, 764, 671, 569, 464, 360, 264,
        181, 115, 71,  50,  55,  83,  135, 207, 295, 394,
        640, 765, 864, 927, 949, 926, 862, 762, 637, 497,
        358, 233, 134, 71,  50,  72,  136, 236, 361, 501,
        640, 765, 864, 927, 949, 926, 862, 762, 637, 497,
        358, 233, 134, 71,  50,  72,  136, 236, 361, 501,
        392, 293, 205, 134, 82,  54,  51,  72,  117, 182,
        266, 362, 466, 572, 673, 765, 843, 901, 937, 949,
        936, 899, 840, 762, 669, 567, 461, 358, 262, 179,
        114, 70,  50,  55,  84,  136, 209, 297, 396, 501
    };

    // predictor state and register copies
    logic [10:0] nav_pos;
    logic [5:0]  gold_idx;
    logic [15:0] clk_count;
    logic [9:0]  slot_ofs [TABLE_SLOTS];
    logic [7:0]  slot_amp [TABLE_SLOTS];
    logic        reg_ilace;
    logic        reg_comp;
    logic [7:0]  reg_floor;
    logic [7:0]  reg_ceil;

    // predicted result beats in order
    ncps_pkg::ncps_out_t due_ms [$];

    // one nav slot at ramp time t, unpowered slots sit at zero phase
    function automatic ncps_pkg::ncps_chan_t slot_level(input int slot, input int t);
        ncps_pkg::ncps_chan_t ch;
        int ofs;
        int amp;
        ofs = 0;
        amp = int'(reg_floor);
        if (slot < TABLE_SLOTS) begin
            ofs = int'(slot_ofs[slot]);
            amp = int'(slot_amp[slot]);
        end
        ch.power = 8'(amp);
        if (amp > int'(reg_floor)) begin
            if (t < 40)
                ch.phase = 10'((ZERO_PHASE + ofs + t * 40) % 1000);
            else
                ch.phase = 10'((ZERO_PHASE + ofs + 2000 - (t - 40) * 40) % 1000);
        end else begin
            ch.phase = 10'(ZERO_PHASE);
        end
        return ch;
    endfunction

    // work out one millisecond and step the cycle position
    task automatic next_millisecond(output ncps_pkg::ncps_out_t r);
        int p;
        int base;
        int rel;
        int shift;
        logic [1:0] dibit;
        ncps_pkg::ncps_chan_t c1;
        ncps_pkg::ncps_chan_t c2;
        p = int'(nav_pos);
        base = reg_comp ? 80 : 0;
        c1.phase = 10'(ZERO_PHASE);
        c1.power = reg_floor;
        c2 = c1;
        if (p < 45 || (p >= 85 && p < 95) || (p >= 115 && p < 120) ||
            (p >= 300 && p < 340)) begin
            c1.power = reg_ceil;
        end else if (p < 85) begin
            // trigger template chosen by the gold-code bit
            c1.phase = 10'(TONE_ROM[base + (GOLD_SEQ[gold_idx] ? 40 : 0) + p - 45]);
            c1.power = reg_ceil;
        end else if (p < 115) begin
            // clock field: 50 Hz template rotated by a dibit of the clock count
            dibit = 2'(clk_count >> (2 * int'(gold_idx[2:0])));
            if (gold_idx[5])
                dibit = ~dibit;
            case (dibit)
                2'd0:    shift = 0;
                2'd1:    shift = 5;
                2'd2:    shift = 15;
                default: shift = 10;
            endcase
            c1.phase = 10'(TONE_ROM[base + (p - 95 + shift) % 20]);
            c1.power = reg_ceil;
        end else if (p >= F1_FIRST && p < F1_FIRST + NAV_SLOTS * 80) begin
            rel = p - F1_FIRST;
            c1 = slot_level(rel / 80, rel % 80);
            if (reg_ilace)
                c2 = slot_level(rel / 80 + (gold_idx[0] ? 16 : 8), rel % 80);
        end else if (p >= F2_FIRST && p < F2_FIRST + NAV_SLOTS * 80) begin
            rel = p - F2_FIRST;
            c2 = slot_level(rel / 80, rel % 80);
            if (reg_ilace)
                c1 = slot_level(rel / 80 + (gold_idx[0] ? 8 : 16), rel % 80);
        end else begin
            // gap and guards
            c1.phase = 10'(GAP_PHASE);
            c2.phase = 10'(GAP_PHASE);
        end
        r.ch1_phase = c1.phase;
        r.ch2_phase = c2.phase;
        r.f1_power  = c1.power;
        r.f2_power  = c2.power;
        r.cycle_end = (p + 1 >= CYCLE_LEN);
        // end of cycle advances the gold index, its wrap the clock count
        if (r.cycle_end) begin
            nav_pos  = '0;
            gold_idx = gold_idx + 1'b1;
            if (gold_idx == 0)
                clk_count = clk_count + 1'b1;
        end else begin
            nav_pos = nav_pos + 1'b1;
        end
    endtask

    // compare one field, report only the first few
    task automatic check_field(input string what, input logic [9:0] want_v,
                               input logic [9:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
        end
    endtask

    // watch the input, result and configuration interfaces at the rising edge
    always @(posedge aclk) begin : watch
        ncps_pkg::ncps_out_t want;
        if (!aresetn) begin
            nav_pos   = '0;
            gold_idx  = '0;
            clk_count = '0;
            reg_ilace = 1'b0;
            reg_comp  = 1'b0;
            reg_floor = '0;
            reg_ceil  = 8'hFF;
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                slot_ofs[k] = '0;
                slot_amp[k] = '0;
            end
            due_ms.delete();
            mismatches = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ncps_pkg::CFG_INTERLACED: reg_ilace = cfg_data[0];
                    ncps_pkg::CFG_RX_COMP:    reg_comp  = cfg_data[0];
                    ncps_pkg::CFG_PWR_FLOOR:  reg_floor = cfg_data;
                    ncps_pkg::CFG_PWR_CEIL:   reg_ceil  = cfg_data;
                    default:                  ;
                endcase
            end
            // result beats against the oldest prediction
            if (m_valid && m_ready) begin
                if (due_ms.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with no tick outstanding", $time);
                end else begin
                    want = due_ms.pop_front();
                    check_field("ch1_phase", want.ch1_phase, m_data.ch1_phase);
                    check_field("ch2_phase", want.ch2_phase, m_data.ch2_phase);
                    check_field("f1_power", 10'(want.f1_power), 10'(m_data.f1_power));
                    check_field("f2_power", 10'(want.f2_power), 10'(m_data.f2_power));
                    check_field("cycle_end", 10'(want.cycle_end), 10'(m_data.cycle_end));
                end
            end
            // input beats: table writes or ticks
            if (s_valid && s_ready) begin
                if (s_data.cmd == ncps_pkg::CMD_WRITE) begin
                    if (s_data.slot_index < TABLE_SLOTS) begin
                        slot_ofs[s_data.slot_index] = s_data.slot_offset;
                        slot_amp[s_data.slot_index] = s_data.slot_power;
                    end
                end else begin
                    next_millisecond(want);
                    due_ms.push_back(want);
                end
            end
        end
        outstanding = due_ms.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for the navigation cycle sequencer: clock, reset, stimulus and verdict
module tb_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_BEATS   = 80;
    localparam int PHASE_BEATS  = 300;
    localparam int IDLE_PCT     = 38;
    localparam int DRAIN_CYCLES = 4;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    ncps_pkg::ncps_in_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    ncps_pkg::ncps_out_t             m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ncps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ncps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic       s_took    = 1'b0;
    logic       cfg_took  = 1'b0;
    logic       idle_on   = 1'b1;
    logic [7:0] cur_floor = '0;
    int         mismatches;
    int         outstanding;
    int         cycles     = 0;
    int         ticks_sent = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nav_cycle_phase_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ncps_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // handshakes seen at the rising edge, read back at the falling edge
    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // run limit
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(negedge aclk)
        m_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic ncps_pkg::ncps_in_t make_beat(input logic cmd, input int idx,
                                                     input int ofs, input int pwr);
        ncps_pkg::ncps_in_t b;
        b.cmd         = cmd;
        b.slot_index  = 5'(idx);
        b.slot_offset = 10'(ofs);
        b.slot_power  = 8'(pwr);
        return b;
    endfunction

    // mostly in-range slots, offsets and powers biased to extremes and the floor
    function automatic ncps_pkg::ncps_in_t random_beat(input int write_pct);
        int idx;
        int ofs;
        int pwr;
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
        case ($urandom_range(0, 7))
            0:       ofs = 0;
            1:       ofs = 999;
            default: ofs = $urandom_range(0, 999);
        endcase
        case ($urandom_range(0, 7))
            0:       pwr = cur_floor;
            1:       pwr = cur_floor + 1;
            2:       pwr = 255;
            3:       pwr = 0;
            default: pwr = $urandom_range(0, 255);
        endcase
        return make_beat(($urandom_range(0, 99) < write_pct) ?
                         ncps_pkg::CMD_WRITE : ncps_pkg::CMD_TICK, idx, ofs, pwr);
    endfunction

    // one input beat, called at a falling edge, returns at the one after acceptance
    task automatic send_beat(input ncps_pkg::ncps_in_t beat);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(negedge aclk); while (!s_took);
        if (beat.cmd == ncps_pkg::CMD_TICK)
            ticks_sent++;
    endtask

    // hold off until every tick has its result, then let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // write all four registers
    task automatic apply_setting(input logic ilace, input logic comp,
                                 input logic [7:0] floor_v, input logic [7:0] ceil_v);
        logic [ncps_pkg::CFG_DATA_W-1:0] vals [4];
        vals[ncps_pkg::CFG_INTERLACED] = {7'd0, ilace};
        vals[ncps_pkg::CFG_RX_COMP]    = {7'd0, comp};
        vals[ncps_pkg::CFG_PWR_FLOOR]  = floor_v;
        vals[ncps_pkg::CFG_PWR_CEIL]   = ceil_v;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= ncps_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            do @(negedge aclk); while (!cfg_took);
        end
        cfg_valid <= 1'b0;
        cur_floor = floor_v;
    endtask

    initial begin : stimulus
        // hold reset, then release it
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        apply_setting(1'b0, 1'b0, 8'h00, 8'hFF);

        // directed: table extremes, ignored indexes and a slot held at the floor
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 0, 999, 255));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 7, 0, 1));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 23, 999, 254));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 24, 123, 200));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 31, 512, 255));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 3, 250, 0));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 8, 500, 128));
        send_beat(make_beat(ncps_pkg::CMD_WRITE, 16, 1, 77));
        send_beat(make_beat(ncps_pkg::CMD_TICK, 31, 999, 255));
        repeat (9) send_beat(make_beat(ncps_pkg::CMD_TICK, 0, 0, 0));

        // random phases under several register settings, extremes first
        for (int s = 0; s < 5; s++) begin
            drain();
            case (s)
                0:       apply_setting(1'b1, 1'b1, 8'h00, 8'hFF);
                1:       apply_setting(1'b1, 1'b0, 8'hFF, 8'h00);
                2:       apply_setting(1'b0, 1'b1, 8'h00, 8'h00);
                3:       apply_setting(1'b1, 1'b1, 8'($urandom_range(1, 254)),
                                       8'($urandom_range(0, 255)));
                default: apply_setting(1'b0, 1'b0, 8'($urandom_range(1, 254)),
                                       8'($urandom_range(0, 255)));
            endcase
            repeat (PHASE_BEATS) send_beat(random_beat(15));
        end

        // stretch with no idling on either side
        drain();
        apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 40)), 8'($urandom_range(0, 255)));
        idle_on <= 1'b0;
        repeat (LONG_BEATS) send_beat(random_beat(1));
        idle_on <= 1'b1;

        // wait for the last results, then the verdict
        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
